[rtl/core/bbc_pkg.sv]
// Shared types and constants of the block buffer cache LRU unit.
// Used by the scan unit and the top level; depends on nothing.
package bbc_pkg;

    localparam int DEF_NUM_ENTRIES = 32;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int CNT_W  = 8;
    localparam int TICK_W = 32;
    localparam int IDX_W  = 5;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        FN_GET     = 2'd0,
        FN_RELEASE = 2'd1,
        FN_PIN     = 2'd2,
        FN_UNPIN   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [CNT_W-1:0]  cnt;
        logic [TICK_W-1:0] last;
    } t_word;

    localparam int WORD_W = $bits(t_word);

    typedef struct packed {
        logic hit;
        logic vic_found;
    } t_scan_flags;

endpackage

[rtl/core/bbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package needed.
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[rtl/core/bbc_scan.sv]
// Shared compare unit: one entry per cycle while i_eval is high, tracks first tag match and oldest free entry.
// Depends on bbc_pkg.
module bbc_scan
    import bbc_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_eval,
    input  logic [$clog2(NUM_ENTRIES)-1:0] i_eval_idx,
    input  t_word                          i_word,
    input  logic                           i_present,
    input  logic                           i_meta_vld,
    input  logic [DEV_W-1:0]               i_device,
    input  logic [BLK_W-1:0]               i_block_number,
    output t_scan_flags                    o_flags,
    output logic [$clog2(NUM_ENTRIES)-1:0] o_hit_idx,
    output logic [CNT_W-1:0]               o_hit_cnt,
    output logic [TICK_W-1:0]              o_hit_last,
    output logic [$clog2(NUM_ENTRIES)-1:0] o_vic_idx
);

    localparam int IW = $clog2(NUM_ENTRIES);

    t_scan_flags       r_flags;
    logic [IW-1:0]     r_hit_idx;
    logic [CNT_W-1:0]  r_hit_cnt;
    logic [TICK_W-1:0] r_hit_last;
    logic [IW-1:0]     r_vic_idx;
    logic [TICK_W-1:0] r_oldest;

    logic [CNT_W-1:0]  cnt;
    logic [TICK_W-1:0] last;
    logic              match;
    logic              older;

    // Entries never written read as zero count and zero stamp.
    assign cnt   = i_meta_vld ? i_word.cnt  : '0;
    assign last  = i_meta_vld ? i_word.last : '0;
    assign match = i_present && (i_word.dev == i_device) && (i_word.blk == i_block_number);
    assign older = (cnt == '0) && (!r_flags.vic_found || (last < r_oldest));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_flags <= '0;
        end else if (i_eval) begin
            if (!r_flags.hit && match) begin
                r_flags.hit <= 1'b1;
                r_hit_idx   <= i_eval_idx;
                r_hit_cnt   <= cnt;
                r_hit_last  <= last;
            end
            if (older) begin
                r_flags.vic_found <= 1'b1;
                r_vic_idx         <= i_eval_idx;
                r_oldest          <= last;
            end
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_cnt  = r_hit_cnt;
    assign o_hit_last = r_hit_last;
    assign o_vic_idx  = r_vic_idx;

endmodule

[rtl/core/block_buffer_cache_lru_unit.sv]
// Top level of the block buffer cache LRU unit: sequencer, valid bits and entry RAM.
// Depends on bbc_pkg, bbc_ram and bbc_scan.
//
//  Channel   Handshake           Payload
//  request   start, busy         i_func, i_device, i_block_number, i_entry_index, i_tick_now
//  result    o_done (strobe)     o_result_index, o_need_read, o_status
//
// A get scans every RAM entry before the result beat: the scan unit
// checks one RAM entry per cycle. Release, pin and unpin pass through S_FETCH and then S_UPDATE.
// A new start is taken in the cycle the result beat is shown.
// Reset clears all valid bits at once; no clearing pass is needed.
// The result beat lasts one cycle and cannot be stalled.
module block_buffer_cache_lru_unit
    import bbc_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_func,
    input  logic [DEV_W-1:0]  i_device,
    input  logic [BLK_W-1:0]  i_block_number,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [TICK_W-1:0] i_tick_now,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_result_index,
    output logic              o_need_read,
    output logic [1:0]        o_status
);

    localparam int IW = $clog2(NUM_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_UPDATE
    } t_state;

    t_state            r_state;
    t_func             r_func;
    logic [DEV_W-1:0]  r_dev;
    logic [BLK_W-1:0]  r_blk;
    logic [IDX_W-1:0]  r_idx;
    logic [TICK_W-1:0] r_tick;
    logic              r_inr;
    logic [IW:0]       r_cnt;
    logic              r_pend;
    logic [IW-1:0]     r_pidx;
    logic [NUM_ENTRIES-1:0] r_tp;
    logic [NUM_ENTRIES-1:0] r_dv;
    logic [NUM_ENTRIES-1:0] r_mvld;
    logic              r_done;
    logic [IDX_W-1:0]  r_res_idx;
    logic              r_need_read;
    t_status           r_status;

    logic              accept;
    logic              scan_clear;
    logic              scan_issue;
    logic              scan_last;
    logic [IW-1:0]     ent_addr;
    logic              ram_rd_en;
    logic [IW-1:0]     ram_rd_addr;
    logic              ram_wr_en;
    logic [IW-1:0]     ram_wr_addr;
    t_word             ram_wr_data;
    t_word             ram_rd_data;
    t_word             cur;
    t_scan_flags       sc_flags;
    logic [IW-1:0]     sc_hit_idx;
    logic [CNT_W-1:0]  sc_hit_cnt;
    logic [TICK_W-1:0] sc_hit_last;
    logic [IW-1:0]     sc_vic_idx;

    assign accept     = start && !busy;
    assign scan_clear = accept && (t_func'(i_func) == FN_GET);
    assign scan_issue = (r_state == S_SCAN) && (r_cnt < (IW+1)'(NUM_ENTRIES));
    assign scan_last  = (r_state == S_SCAN) && !scan_issue && !r_pend;
    assign ent_addr   = IW'(r_idx);

    // Entry word as seen by release, pin and unpin; unwritten entries read as zero.
    assign cur = r_mvld[ent_addr] ? ram_rd_data : '0;

    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_cnt[IW-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = ent_addr;
        ram_wr_data = cur;
        unique case (r_state)
            S_SCAN: begin
                ram_rd_en = scan_issue;
                if (scan_last) begin
                    if (sc_flags.hit) begin
                        ram_wr_en   = (sc_hit_cnt != COUNT_MAX);
                        ram_wr_addr = sc_hit_idx;
                        ram_wr_data = '{dev: r_dev, blk: r_blk, cnt: sc_hit_cnt + 1'b1,
                                        last: sc_hit_last};
                    end else begin
                        ram_wr_en   = sc_flags.vic_found;
                        ram_wr_addr = sc_vic_idx;
                        ram_wr_data = '{dev: r_dev, blk: r_blk, cnt: CNT_W'(1), last: '0};
                    end
                end
            end
            S_FETCH: begin
                ram_rd_en   = r_inr;
                ram_rd_addr = ent_addr;
            end
            S_UPDATE: begin
                if (r_inr) begin
                    if (r_func == FN_PIN) begin
                        ram_wr_en       = (cur.cnt != COUNT_MAX);
                        ram_wr_data.cnt = cur.cnt + 1'b1;
                    end else begin
                        ram_wr_en       = (cur.cnt != '0);
                        ram_wr_data.cnt = cur.cnt - 1'b1;
                        if (r_func == FN_RELEASE && cur.cnt == CNT_W'(1)) begin
                            ram_wr_data.last = r_tick;
                        end
                    end
                end
            end
            default: begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
            r_tp    <= '0;
            r_dv    <= '0;
            r_mvld  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func <= t_func'(i_func);
                        r_dev  <= i_device;
                        r_blk  <= i_block_number;
                        r_idx  <= i_entry_index;
                        r_tick <= i_tick_now;
                        r_inr  <= int'(i_entry_index) < NUM_ENTRIES;
                        r_cnt  <= '0;
                        r_pend <= 1'b0;
                        r_state <= (t_func'(i_func) == FN_GET) ? S_SCAN : S_FETCH;
                    end
                end
                S_SCAN: begin
                    r_pend <= scan_issue;
                    r_pidx <= r_cnt[IW-1:0];
                    if (scan_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (scan_last) begin
                        r_done      <= 1'b1;
                        r_need_read <= 1'b0;
                        r_status    <= ST_OK;
                        r_state     <= S_IDLE;
                        if (sc_flags.hit) begin
                            r_res_idx <= IDX_W'(sc_hit_idx);
                            if (sc_hit_cnt == COUNT_MAX) begin
                                r_status <= ST_OVER;
                            end else begin
                                r_need_read      <= !r_dv[sc_hit_idx];
                                r_dv[sc_hit_idx] <= 1'b1;
                            end
                        end else if (sc_flags.vic_found) begin
                            r_res_idx          <= IDX_W'(sc_vic_idx);
                            r_need_read        <= 1'b1;
                            r_tp[sc_vic_idx]   <= 1'b1;
                            r_dv[sc_vic_idx]   <= 1'b1;
                            r_mvld[sc_vic_idx] <= 1'b1;
                        end else begin
                            r_res_idx <= '0;
                            r_status  <= ST_FULL;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_done      <= 1'b1;
                    r_res_idx   <= r_idx;
                    r_need_read <= 1'b0;
                    r_status    <= ST_OK;
                    r_state     <= S_IDLE;
                    if (r_inr) begin
                        if (r_func == FN_PIN) begin
                            if (cur.cnt == COUNT_MAX) begin
                                r_status <= ST_OVER;
                            end
                        end else if (cur.cnt == '0) begin
                            r_status <= ST_UNDER;
                        end
                        if (ram_wr_en) begin
                            r_mvld[ent_addr] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bbc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(NUM_ENTRIES)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    bbc_scan #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (scan_clear),
        .i_eval        (r_pend && (r_state == S_SCAN)),
        .i_eval_idx    (r_pidx),
        .i_word        (ram_rd_data),
        .i_present     (r_tp[r_pidx]),
        .i_meta_vld    (r_mvld[r_pidx]),
        .i_device      (r_dev),
        .i_block_number(r_blk),
        .o_flags       (sc_flags),
        .o_hit_idx     (sc_hit_idx),
        .o_hit_cnt     (sc_hit_cnt),
        .o_hit_last    (sc_hit_last),
        .o_vic_idx     (sc_vic_idx)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_index = r_res_idx;
    assign o_need_read    = r_need_read;
    assign o_status       = r_status;

endmodule

[test/tb_block_buffer_cache_lru_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for block_buffer_cache_lru_unit: directed and random get, release,
// pin and unpin beats, checked against a scoreboard that predicts tags, counts and LRU victims.
// Depends on bbc_pkg and the block_buffer_cache_lru_unit RTL.
module tb_block_buffer_cache_lru_unit;
    import bbc_pkg::*;

    localparam int NUM_ENTRIES = DEF_NUM_ENTRIES;
    localparam int ITEM_TARGET = 1900;
    localparam int POOL_SIZE   = 48;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             need_read;
        t_status          status;
    } cache_reply_t;

    class cache_scoreboard;
        bit              held   [NUM_ENTRIES];
        bit [DEV_W-1:0]  tag_dev[NUM_ENTRIES];
        bit [BLK_W-1:0]  tag_blk[NUM_ENTRIES];
        bit [CNT_W-1:0]  refs   [NUM_ENTRIES];
        bit [TICK_W-1:0] stamp  [NUM_ENTRIES];
        bit              loaded [NUM_ENTRIES];
        cache_reply_t    pending_replies[$];
        int              errors;

        function void log_request(t_func f, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                                  logic [IDX_W-1:0] idx, logic [TICK_W-1:0] tick);
            cache_reply_t    r;
            bit              hit;
            bit              found;
            int              victim;
            bit [TICK_W-1:0] oldest;
            r = '{index: idx, need_read: 1'b0, status: ST_OK};
            if (f == FN_GET) begin
                hit = 1'b0;
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (!hit && held[i] && tag_dev[i] == dev && tag_blk[i] == blk) begin
                        hit = 1'b1;
                        r.index = IDX_W'(i);
                        if (refs[i] == COUNT_MAX) begin
                            r.status = ST_OVER;
                        end else begin
                            refs[i]++;
                            r.need_read = !loaded[i];
                            loaded[i] = 1'b1;
                        end
                    end
                end
                if (!hit) begin
                    found  = 1'b0;
                    victim = 0;
                    oldest = '0;
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (refs[i] == 0 && (!found || stamp[i] < oldest)) begin
                            found  = 1'b1;
                            victim = i;
                            oldest = stamp[i];
                        end
                    end
                    if (!found) begin
                        r.index  = '0;
                        r.status = ST_FULL;
                    end else begin
                        held[victim]    = 1'b1;
                        tag_dev[victim] = dev;
                        tag_blk[victim] = blk;
                        refs[victim]    = CNT_W'(1);
                        stamp[victim]   = '0;
                        loaded[victim]  = 1'b1;
                        r.index     = IDX_W'(victim);
                        r.need_read = 1'b1;
                    end
                end
            end else if (int'(idx) < NUM_ENTRIES) begin
                if (f == FN_PIN) begin
                    if (refs[idx] == COUNT_MAX) begin
                        r.status = ST_OVER;
                    end else begin
                        refs[idx]++;
                    end
                end else if (refs[idx] == 0) begin
                    r.status = ST_UNDER;
                end else begin
                    refs[idx]--;
                    if (f == FN_RELEASE && refs[idx] == 0) begin
                        stamp[idx] = tick;
                    end
                end
            end
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [IDX_W-1:0] index, logic need_read, logic [1:0] status);
            cache_reply_t e;
            if (pending_replies.size() == 0) begin
                $error("result beat with no request outstanding: result_index %0d", index);
                errors++;
                return;
            end
            e = pending_replies.pop_front();
            if (index !== e.index) begin
                $error("result_index: expected %0d, actual %0d", e.index, index);
                errors++;
            end
            if (need_read !== e.need_read) begin
                $error("need_read: expected %0b, actual %0b", e.need_read, need_read);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d (%s), actual %0d", e.status, e.status.name(),
                       status);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_func;
    logic [DEV_W-1:0]  i_device;
    logic [BLK_W-1:0]  i_block_number;
    logic [IDX_W-1:0]  i_entry_index;
    logic [TICK_W-1:0] i_tick_now;
    logic              o_done;
    logic [IDX_W-1:0]  o_result_index;
    logic              o_need_read;
    logic [1:0]        o_status;

    cache_scoreboard   sb;
    int                items_sent;
    int                quiet_cycles;
    bit                steady;
    bit                saturated;
    logic [TICK_W-1:0] tick_base;
    logic [DEV_W-1:0]  pool_dev[POOL_SIZE];
    logic [BLK_W-1:0]  pool_blk[POOL_SIZE];

    block_buffer_cache_lru_unit #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_device(i_device),
        .i_block_number(i_block_number),
        .i_entry_index(i_entry_index),
        .i_tick_now(i_tick_now),
        .o_done(o_done),
        .o_result_index(o_result_index),
        .o_need_read(o_need_read),
        .o_status(o_status)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_reply(o_result_index, o_need_read, o_status);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function logic [TICK_W-1:0] next_tick();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2) begin
            tick_base = tick_base + $urandom_range(1, 1000);
            return tick_base;
        end else if (r == 2) begin
            return $urandom_range(0, 3);
        end
        return $urandom;
    endfunction

    function logic [IDX_W-1:0] pick_referenced();
        int first;
        int j;
        first = $urandom_range(0, NUM_ENTRIES - 1);
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            j = (first + k) % NUM_ENTRIES;
            if (sb.refs[j] != 0) begin
                return IDX_W'(j);
            end
        end
        return IDX_W'(first);
    endfunction

    task automatic send_item(input t_func f, input logic [DEV_W-1:0] dev,
                             input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] idx,
                             input logic [TICK_W-1:0] tick);
        if (!steady && $urandom_range(0, 99) < 33) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= f;
        i_device       <= dev;
        i_block_number <= blk;
        i_entry_index  <= idx;
        i_tick_now     <= tick;
        do begin
            @(posedge i_clk);
        end while (busy);
        sb.log_request(f, dev, blk, idx, tick);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_get(input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk);
        send_item(FN_GET, dev, blk, IDX_W'($urandom), $urandom);
    endtask

    task automatic send_count(input t_func f, input logic [IDX_W-1:0] idx,
                              input logic [TICK_W-1:0] tick);
        send_item(f, DEV_W'($urandom), $urandom, idx, tick);
    endtask

    task automatic mixed_burst(input int len);
        int k;
        int p;
        repeat (len) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                if ($urandom_range(0, 3) != 0) begin
                    p = $urandom_range(0, POOL_SIZE - 1);
                    send_get(pool_dev[p], pool_blk[p]);
                end else begin
                    send_get(DEV_W'($urandom), $urandom);
                end
            end else if (k < 85 && k >= 70) begin
                send_count(FN_PIN, IDX_W'($urandom), next_tick());
            end else begin
                send_count(k < 70 ? FN_RELEASE : FN_UNPIN,
                           $urandom_range(0, 9) < 7 ? pick_referenced() : IDX_W'($urandom),
                           next_tick());
            end
        end
    endtask

    task automatic saturate_entry();
        int e;
        e = $urandom_range(0, NUM_ENTRIES - 1);
        for (int k = 0; k < NUM_ENTRIES && !sb.held[e]; k++) begin
            e = (e + 1) % NUM_ENTRIES;
        end
        steady = 1'b1;
        while (sb.refs[e] != COUNT_MAX) begin
            send_count(FN_PIN, IDX_W'(e), next_tick());
        end
        send_count(FN_PIN, IDX_W'(e), next_tick());
        send_count(FN_PIN, IDX_W'(e), next_tick());
        if (sb.held[e]) begin
            send_get(sb.tag_dev[e], sb.tag_blk[e]);
        end
        while (sb.refs[e] != 0) begin
            send_count($urandom_range(0, 1) ? FN_RELEASE : FN_UNPIN, IDX_W'(e), next_tick());
        end
        send_count(FN_RELEASE, IDX_W'(e), next_tick());
        steady = 1'b0;
        saturated = 1'b1;
    endtask

    initial begin
        int kind;
        sb             = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = FN_GET;
        i_device       = '0;
        i_block_number = '0;
        i_entry_index  = '0;
        i_tick_now     = '0;
        items_sent     = 0;
        quiet_cycles   = 0;
        steady         = 1'b0;
        saturated      = 1'b0;
        tick_base      = '0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_dev[k] = DEV_W'($urandom_range(0, 7));
            pool_blk[k] = (k % 4 == 0) ? $urandom : $urandom_range(0, 63);
        end
        pool_dev[0] = '1;
        pool_blk[0] = '1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats: misses, hits, count changes and the corner cases of each.
        send_get('0, '0);
        send_get('0, '0);
        send_get('1, '1);
        send_count(FN_RELEASE, 5'd0, 32'd100);
        send_count(FN_RELEASE, 5'd0, 32'd200);
        send_count(FN_RELEASE, 5'd0, 32'd300);
        send_count(FN_UNPIN, 5'd31, '1);
        send_count(FN_PIN, 5'd31, '0);
        send_count(FN_UNPIN, 5'd31, 32'd50);
        send_get('0, '0);
        send_get(8'h01, 32'h0000_0005);
        send_count(FN_PIN, 5'd1, '1);
        send_count(FN_RELEASE, 5'd1, '1);
        send_count(FN_RELEASE, 5'd1, '1);
        send_count(FN_RELEASE, 5'd0, 32'h0000_0007);
        send_get(8'hAA, 32'h5555_5555);
        send_get(8'h55, 32'hAAAA_AAAA);
        send_count(FN_PIN, 5'd2, '0);
        send_get('1, '1);
        send_count(FN_UNPIN, 5'd4, '0);
        send_count(FN_RELEASE, 5'd4, 32'd9);

        while (items_sent < ITEM_TARGET) begin
            if (!saturated && items_sent > 700) begin
                saturate_entry();
            end else begin
                steady = ($urandom_range(0, 99) < 15);
                kind = $urandom_range(0, 99);
                if (kind < 55) begin
                    mixed_burst($urandom_range(20, 60));
                end else if (kind < 70) begin
                    repeat (NUM_ENTRIES + $urandom_range(2, 8)) begin
                        send_get(DEV_W'($urandom), $urandom);
                    end
                end else begin
                    repeat ($urandom_range(30, 80)) begin
                        send_count($urandom_range(0, 9) != 0 ? FN_RELEASE : FN_UNPIN,
                                   pick_referenced(), next_tick());
                    end
                end
                steady = 1'b0;
            end
        end
        start <= 1'b0;

        while (sb.pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_ENTRIES + 8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/bbc_pkg.sv
rtl/core/bbc_ram.sv
rtl/core/bbc_scan.sv
rtl/core/block_buffer_cache_lru_unit.sv
test/tb_block_buffer_cache_lru_unit.sv
